@@ hdl/brs_pkg.sv @@
// Shared types, constants and helpers for the Bresenham ray stepper.
// Used by brs_ctrl, brs_datapath and bresenham_ray_stepper.
package brs_pkg;

  localparam int DELTA_W   = 12;  // config deltas, two's complement
  localparam int HEAD_W    = 9;   // heading in degrees
  localparam int ADV_W     = 9;   // advance request, two's complement
  localparam int OFS_W     = 9;   // offset outputs, two's complement
  localparam int ERR_W     = 13;  // error accumulator
  localparam int TOTAL_W   = 16;  // saturating step total
  localparam int CFG_IDX_W = 2;

  localparam int MAX_ADVANCE_DEF = 255;
  localparam int QUAD_DEG        = 90;

  // Quadrant sign pairs: bit q set means that axis is negated in quadrant q.
  localparam logic [3:0] QUAD_NEG_X = 4'b0110;
  localparam logic [3:0] QUAD_NEG_Y = 4'b1100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELTA_X     = 2'd0,
    REG_DELTA_Y     = 2'd1,
    REG_HEADING_DEG = 2'd2,
    REG_ENDLESS     = 2'd3
  } brs_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } brs_state_t;

  typedef struct packed {
    logic load;  // start of a new request: clear step counts
    logic step;  // take one tile step
  } brs_ctl_t;

  // Quadrant index (heading / 90) mod 4, by compare against multiples of 90.
  function automatic logic [1:0] heading_quad(input logic [HEAD_W-1:0] heading);
    logic [2:0] qd;
    qd = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if ({1'b0, heading} >= (HEAD_W + 1)'(k * QUAD_DEG)) begin
        qd = 3'(k);
      end
    end
    return qd[1:0];
  endfunction

endpackage

@@ hdl/bresenham_ray_stepper.sv @@
// Top level of the Bresenham ray stepper: configuration registers,
// axis selection, quadrant signs and end test. Depends on brs_pkg,
// brs_ctrl and brs_datapath.
//
// Usage: load delta_x, delta_y, heading_deg and endless through the write
// port (cfg_we, cfg_index, cfg_data) while the block is idle. Then send
// requests on the input channel (in_valid, in_stall, advance_count); each
// beat yields one result beat on the output channel (out_valid, out_stall,
// offset_x, offset_y, vertical_major, at_end).
// The request is taken only when the block is idle. It then runs one
// accumulator step per tile in the shared step unit for a request of n tiles
// (n = |advance_count| capped at MAX_ADVANCE), then presents the result beat.
// The next request is taken the cycle after the result beat goes out, so the
// block takes no new request before it is through with the last one.
// While out_stall is high the result beat holds and no request is taken.
// Reset clears the registers, the error accumulator and the step total.
module bresenham_ray_stepper
  import brs_pkg::*;
#(
  parameter int MAX_ADVANCE = MAX_ADVANCE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELTA_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [ADV_W-1:0] advance_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [OFS_W-1:0] offset_x,
  output logic signed [OFS_W-1:0] offset_y,
  output logic                 vertical_major,
  output logic                 at_end
);

  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic [HEAD_W-1:0]         heading_deg;
  logic                      endless;

  logic [DELTA_W-1:0] abs_x, abs_y, major, minor;
  logic               vert;
  logic [ADV_W-1:0]   magnitude;
  logic               req_neg;
  brs_ctl_t           ctl;
  logic [OFS_W-1:0]   major_steps, minor_steps, steps_x, steps_y;
  logic               neg;
  logic [TOTAL_W-1:0] step_total;
  logic [1:0]         quad;
  logic               flip_x, flip_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_x     <= '0;
      delta_y     <= '0;
      heading_deg <= '0;
      endless     <= 1'b0;
    end else if (cfg_we) begin
      case (brs_reg_t'(cfg_index))
        REG_DELTA_X:     delta_x     <= cfg_data;
        REG_DELTA_Y:     delta_y     <= cfg_data;
        REG_HEADING_DEG: heading_deg <= cfg_data[HEAD_W-1:0];
        REG_ENDLESS:     endless     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Magnitudes fit unsigned in the same width, including the most negative value.
  always_comb begin
    abs_x = delta_x[DELTA_W-1] ? DELTA_W'(-delta_x) : DELTA_W'(delta_x);
    abs_y = delta_y[DELTA_W-1] ? DELTA_W'(-delta_y) : DELTA_W'(delta_y);
    vert  = (abs_x <= abs_y);
    major = vert ? abs_y : abs_x;
    minor = vert ? abs_x : abs_y;
  end

  assign req_neg   = advance_count[ADV_W-1];
  assign magnitude = req_neg ? ADV_W'(-advance_count) : ADV_W'(advance_count);

  brs_ctrl #(
    .MAX_ADVANCE(MAX_ADVANCE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .magnitude (magnitude),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  brs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .load_neg    (req_neg),
    .major       (major),
    .minor       (minor),
    .major_steps (major_steps),
    .minor_steps (minor_steps),
    .neg         (neg),
    .step_total  (step_total)
  );

  // Quadrant sign and backward request combine into one negate per axis.
  always_comb begin
    quad    = heading_quad(heading_deg);
    flip_x  = QUAD_NEG_X[quad] ^ neg;
    flip_y  = QUAD_NEG_Y[quad] ^ neg;
    steps_x = vert ? minor_steps : major_steps;
    steps_y = vert ? major_steps : minor_steps;
    offset_x = flip_x ? OFS_W'(-steps_x) : steps_x;
    offset_y = flip_y ? OFS_W'(-steps_y) : steps_y;
    vertical_major = vert;
    // A zero major extent would wrap the end limit, so it is tested apart: always at end.
    at_end = endless || (major == '0) ||
             (step_total >= TOTAL_W'(major - DELTA_W'(1)));
  end

endmodule

@@ hdl/brs_ctrl.sv @@
// Sequencer for the ray stepper: takes a request, counts tile steps,
// then presents the result beat. Depends on brs_pkg.
module brs_ctrl
  import brs_pkg::*;
#(
  parameter int MAX_ADVANCE = MAX_ADVANCE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [ADV_W-1:0] magnitude,
  input  logic             out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output brs_ctl_t         ctl
);

  localparam int CNT_W = $clog2(MAX_ADVANCE + 1);
  localparam int CMP_W = (CNT_W > ADV_W) ? CNT_W : ADV_W;

  brs_state_t       state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] mag_ext;

  // Saturate the request at MAX_ADVANCE.
  always_comb begin
    mag_ext = CMP_W'(magnitude);
    if (mag_ext > CMP_W'(MAX_ADVANCE)) begin
      count_next = CNT_W'(MAX_ADVANCE);
    end else begin
      count_next = mag_ext[CNT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (count_next == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (count == CNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ctl.load  = 1'b0;
    ctl.step  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      ST_RUN:  ctl.step = 1'b1;
      ST_DONE: out_valid = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        count <= count_next;
      end else if (ctl.step) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/brs_datapath.sv @@
// Shared step unit of the ray stepper: error accumulator with one
// add/compare/subtract per tile, step counts and the saturating total.
// Depends on brs_pkg.
module brs_datapath
  import brs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  brs_ctl_t           ctl,
  input  logic               load_neg,
  input  logic [DELTA_W-1:0] major,
  input  logic [DELTA_W-1:0] minor,
  output logic [OFS_W-1:0]   major_steps,
  output logic [OFS_W-1:0]   minor_steps,
  output logic               neg,
  output logic [TOTAL_W-1:0] step_total
);

  logic [ERR_W-1:0] error_accum;
  logic [ERR_W-1:0] error_accum_next;
  logic [ERR_W-1:0] sum;
  logic             take_minor;

  always_comb begin
    sum        = error_accum + ERR_W'(minor);
    take_minor = (sum >= ERR_W'(major));
    error_accum_next = take_minor ? (sum - ERR_W'(major)) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_accum <= '0;
      step_total  <= '0;
    end else if (ctl.step) begin
      error_accum <= error_accum_next;
      if (step_total != '1) begin
        step_total <= step_total + TOTAL_W'(1);
      end
    end
  end

  // Step counts wrap at the offset width; only the low bits reach the output.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      major_steps <= '0;
      minor_steps <= '0;
      neg         <= load_neg;
    end else if (ctl.step) begin
      major_steps <= major_steps + OFS_W'(1);
      if (take_minor) begin
        minor_steps <= minor_steps + OFS_W'(1);
      end
    end
  end

endmodule

@@ tb/brs_ray_checker.sv @@
`timescale 1ns / 100ps
// Result checker for bresenham_ray_stepper: tracks register writes, predicts each
// advance from its own accumulator and step total, and compares result beats in order.
// Depends on brs_pkg.
module brs_ray_checker
  import brs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DELTA_W-1:0]      cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [ADV_W-1:0] advance_count,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OFS_W-1:0] offset_x,
  input  logic signed [OFS_W-1:0] offset_y,
  input  logic                    vertical_major,
  input  logic                    at_end,
  output int                      errors,
  output int                      pending,
  output int                      checked
);

  typedef struct {
    logic signed [OFS_W-1:0] ofs_x;
    logic signed [OFS_W-1:0] ofs_y;
    logic                    vert;
    logic                    ended;
  } ray_result_t;

  logic signed [DELTA_W-1:0] ray_dx;
  logic signed [DELTA_W-1:0] ray_dy;
  logic [HEAD_W-1:0]         ray_heading;
  logic                      ray_endless;
  logic [ERR_W-1:0]          err_acc;
  logic [TOTAL_W-1:0]        total_steps;
  ray_result_t               expected_offsets[$];
  int                        fail_count = 0;
  int                        n_checked = 0;

  // Walk the requested tiles and update the accumulator and the step total.
  function automatic ray_result_t advance_ray(input logic signed [ADV_W-1:0] req);
    int          ax, ay, major, minor, count, n_major, n_minor, sx, sy;
    logic        vert;
    logic [1:0]  quad;
    ray_result_t r;
    ax = (ray_dx < 0) ? -int'(ray_dx) : int'(ray_dx);
    ay = (ray_dy < 0) ? -int'(ray_dy) : int'(ray_dy);
    vert = (ax <= ay);
    major = vert ? ay : ax;
    minor = vert ? ax : ay;
    count = (req < 0) ? -int'(req) : int'(req);
    if (count > MAX_ADVANCE_DEF) count = MAX_ADVANCE_DEF;
    n_major = 0;
    n_minor = 0;
    for (int i = 0; i < count; i++) begin
      err_acc = err_acc + ERR_W'(minor);
      // at most one minor step per tile, even if the error was left large
      if (int'(err_acc) >= major) begin
        n_minor++;
        err_acc = err_acc - ERR_W'(major);
      end
      n_major++;
      if (total_steps != '1) total_steps++;
    end
    sx = vert ? n_minor : n_major;
    sy = vert ? n_major : n_minor;
    quad = 2'(int'(ray_heading) / QUAD_DEG);
    if (QUAD_NEG_X[quad]) sx = -sx;
    if (QUAD_NEG_Y[quad]) sy = -sy;
    if (req < 0) begin
      sx = -sx;
      sy = -sy;
    end
    r.ofs_x = OFS_W'(sx);
    r.ofs_y = OFS_W'(sy);
    r.vert = vert;
    r.ended = ray_endless || (int'(total_steps) >= major - 1);
    return r;
  endfunction

  function automatic void compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    ray_result_t want;
    if (rst) begin
      ray_dx = '0;
      ray_dy = '0;
      ray_heading = '0;
      ray_endless = 1'b0;
      err_acc = '0;
      total_steps = '0;
      expected_offsets.delete();
    end else begin
      if (cfg_we) begin
        case (brs_reg_t'(cfg_index))
          REG_DELTA_X:     ray_dx = cfg_data;
          REG_DELTA_Y:     ray_dy = cfg_data;
          REG_HEADING_DEG: ray_heading = cfg_data[HEAD_W-1:0];
          REG_ENDLESS:     ray_endless = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_offsets.push_back(advance_ray(advance_count));
      if (out_valid && !out_stall) begin
        if (expected_offsets.size() == 0) begin
          $display("%0t result beat with none expected: actual x %0d y %0d vert %0b end %0b",
                   $time, offset_x, offset_y, vertical_major, at_end);
          fail_count++;
        end else begin
          want = expected_offsets.pop_front();
          compare_field("offset_x", int'(want.ofs_x), int'(offset_x));
          compare_field("offset_y", int'(want.ofs_y), int'(offset_y));
          compare_field("vertical_major", int'(want.vert), int'(vertical_major));
          compare_field("at_end", int'(want.ended), int'(at_end));
          n_checked++;
        end
      end
    end
    errors  <= fail_count;
    pending <= expected_offsets.size();
    checked <= n_checked;
  end

endmodule

@@ tb/bresenham_ray_stepper_test.sv @@
`timescale 1ns / 100ps
// Top of the bresenham_ray_stepper testbench: clock, reset, register writes and
// advance requests with random gaps and stalls. Depends on brs_pkg and brs_ray_checker.
module bresenham_ray_stepper_test
  import brs_pkg::*;
();

  localparam int HOLD_CYCLES = 600;
  localparam int SEG_ITEMS   = 132;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [DELTA_W-1:0]      cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [ADV_W-1:0] advance_count;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OFS_W-1:0] offset_x;
  logic signed [OFS_W-1:0] offset_y;
  logic                    vertical_major;
  logic                    at_end;

  int errors, pending, checked;
  int sender_pct = 0;
  int recv_pct   = 0;
  int hold_reqs  = 0;
  int n_sent     = 0;
  int n_writes   = 0;

  bresenham_ray_stepper i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .advance_count,
    .out_valid, .out_stall, .offset_x, .offset_y, .vertical_major, .at_end
  );

  brs_ray_checker i_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .advance_count,
    .out_valid, .out_stall, .offset_x, .offset_y, .vertical_major, .at_end,
    .errors, .pending, .checked
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        for (int k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  task automatic send(input int v);
    if ($urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    advance_count <= ADV_W'(v);
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Drop valid and wait until every result is back and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input brs_reg_t idx, input logic [DELTA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
  endtask

  task automatic load_ray(input int dx_v, input int dy_v, input int hd_v, input int en_v);
    write_reg(REG_DELTA_X, DELTA_W'(dx_v));
    write_reg(REG_DELTA_Y, DELTA_W'(dy_v));
    write_reg(REG_HEADING_DEG, DELTA_W'(hd_v));
    write_reg(REG_ENDLESS, DELTA_W'(en_v));
  endtask

  function automatic int pick_delta();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return -2048;
      1: return 2047;
      2: return 0;
      3: return ($urandom_range(1) != 0) ? 1 : -1;
      4, 5: return $urandom_range(16) - 8;
      default: return int'($urandom() & 32'hFFF);
    endcase
  endfunction

  // Mostly short advances, a fair share at full length to push the step total up.
  function automatic logic signed [ADV_W-1:0] pick_advance();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(2))
        0: return 9'sd255;
        1: return -9'sd255;
        default: return ADV_W'(-256);
      endcase
    end
    if (r < 22) return ADV_W'(($urandom_range(1) != 0) ? $urandom_range(200, 255)
                                                       : -int'($urandom_range(200, 256)));
    if (r < 35) return ADV_W'($urandom());
    return ADV_W'(int'($urandom_range(40)) - 20);
  endfunction

  task automatic random_ray();
    logic [DELTA_W-1:0] en_word;
    en_word = DELTA_W'($urandom());
    en_word[0] = ($urandom_range(3) == 0);
    write_reg(REG_DELTA_X, DELTA_W'(pick_delta()));
    write_reg(REG_DELTA_Y, DELTA_W'(pick_delta()));
    write_reg(REG_HEADING_DEG, DELTA_W'($urandom()));
    write_reg(REG_ENDLESS, en_word);
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_DELTA_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    advance_count <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero vector straight out of reset
    send(0);
    send(1);
    send(-1);
    settle();
    // longest horizontal ray: end not reached yet, full and long requests
    load_ray(-2048, 2047, 0, 0);
    send(1);
    send(255);
    send(-256);
    send(0);
    send(-255);
    settle();
    load_ray(3, -7, 90, 0);
    send(10);
    send(-10);
    settle();
    // remaining quadrants and headings past 359
    for (int i = 0; i < 7; i++) begin
      case (i)
        0: write_reg(REG_HEADING_DEG, 12'd180);
        1: write_reg(REG_HEADING_DEG, 12'd270);
        2: write_reg(REG_HEADING_DEG, 12'd359);
        3: write_reg(REG_HEADING_DEG, 12'd360);
        4: write_reg(REG_HEADING_DEG, 12'd449);
        5: write_reg(REG_HEADING_DEG, 12'd450);
        default: write_reg(REG_HEADING_DEG, 12'hFFF);
      endcase
      send(9);
      settle();
    end
    write_reg(REG_ENDLESS, 12'd1);
    send(5);
    settle();
    // flat ray with no minor extent, then equal extents
    load_ray(2047, 0, 45, 0);
    send(100);
    settle();
    load_ray(-1, 1, 300, 1);
    send(-7);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_pct = 38;
          recv_pct <= 85;
        end
        1: begin
          sender_pct = 85;
          recv_pct <= 38;
        end
        default: begin
          sender_pct = 0;
          recv_pct <= 0;
          hold_reqs <= hold_reqs + 1;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        random_ray();
        repeat (SEG_ITEMS) send(pick_advance());
        settle();
      end
    end

    repeat (260) @(posedge clk);
    $display("sent %0d advances across %0d register writes, %0d results compared",
             n_sent, n_writes, checked);
    $display("included zero vector, all quadrants, headings past 359,");
    $display("full-length and reversed requests, and a long receiver hold-off");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
